@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every edge out of reset
`define SVT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// when trig holds, expr holds in the same cycle
`define SVT_ASSERT_IMP(label, clk, rst_n, trig, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/svt_pkg.sv @@
`timescale 1ns / 1ps
package svt_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

endpackage

@@ hw/rtl/svt_ram.sv @@
`timescale 1ns / 1ps
module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sorted_value_table_unit.sv @@
// Sorted value table: up to CAPACITY signed 32-bit values kept in ascending order.
// Input channel in_*: in_tuser carries the request kind (insert, search, remove),
// in_tdata the value. Result channel out_*: out_tuser carries the status
// (done/found, not found, full, empty), out_tdata the entry count afterwards.
// One result per request.
// The table lives in a single RAM with registered read; a walk visits each entry
// in S_RD (address), then S_CMP (compare and write back).
// Insert walks down from the top, moving each entry above the new value up one
// slot, then writes the value. Search walks up from the first entry until a match
// or the count. Remove walks the whole table, finding the entry and shifting the
// tail down. Full insert, empty remove and unknown kinds skip the walk.
// One request is in work at a time; a new one is taken as soon as its result
// is in the output register.
// A stalled receiver holds the result in the output register; the next
// request may still be worked on and waits only to report.
// Reset empties the table at once (count to zero); RAM contents stay as
// they are and are never read above the count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_value_table_unit
  import svt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_value
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] entry_count, [7] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         idx_dec, idx_inc;
  logic                  found_r, found_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [KEY_W-1:0]      mem_wdata, mem_rdata;

  svt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign idx_dec = idx_r - CW'(1);
  assign idx_inc = idx_r + CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = key_r;
    mem_raddr      = idx_r[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          key_nxt   = in_tdata;
          found_nxt = 1'b0;
          case (in_tuser)
            OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_FIN;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_RD;
              end
            end
            OP_SEARCH: begin
              idx_nxt   = '0;
              state_nxt = S_RD;
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            default: begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end
          endcase
        end
      end
      S_RD: begin
        if (op_r == OP_INSERT) begin
          if (idx_r == '0) begin
            mem_we     = 1'b1;
            count_nxt  = count_r + CW'(1);
            status_nxt = ST_DONE;
            state_nxt  = S_FIN;
          end else begin
            mem_raddr = idx_dec[AW-1:0];
            state_nxt = S_CMP;
          end
        end else if (idx_r == count_r) begin
          if (op_r == OP_REMOVE && found_r) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = ST_DONE;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        case (op_r)
          OP_INSERT: begin
            mem_we = 1'b1;
            if ($signed(mem_rdata) > key_r) begin
              mem_wdata = mem_rdata;
              idx_nxt   = idx_dec;
              state_nxt = S_RD;
            end else begin
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_DONE;
              state_nxt  = S_FIN;
            end
          end
          OP_SEARCH: begin
            if (mem_rdata == key_r) begin
              status_nxt = ST_DONE;
              state_nxt  = S_FIN;
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = S_RD;
            end
          end
          default: begin
            if (found_r) begin
              mem_we    = 1'b1;
              mem_waddr = idx_dec[AW-1:0];
              mem_wdata = mem_rdata;
            end else if (mem_rdata == key_r) begin
              found_nxt = 1'b1;
            end
            idx_nxt   = idx_inc;
            state_nxt = S_RD;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  `SVT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `SVT_ASSERT_IMP(a_count_at_fin, clk, rst_n, count_r != $past(count_r), state_r == S_FIN)
  `SVT_ASSERT_IMP(a_write_in_walk, clk, rst_n, mem_we, state_r == S_RD || state_r == S_CMP)

endmodule
